/* rtl/mbd_pkg.sv */
// Shared widths, register indexes and the configuration type of the button debouncer.
package mbd_pkg;

    localparam int TIME_W  = 32;
    localparam int FIELD_W = 9;
    localparam int DEB_W   = 16;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 1;

    localparam logic [IDX_W-1:0] REG_HOLD_MS       = 1'b0;
    localparam logic [IDX_W-1:0] REG_PRESSED_LEVEL = 1'b1;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd28;
    localparam logic             PRESSED_RESET  = 1'b1;

    typedef struct packed {
        logic [DEB_W-1:0] hold_ms;
        logic             pressed_level;
    } t_cfg;

endpackage

/* rtl/multi_button_debouncer.sv */
// A scan taken in is held in the scan register, and its result is registered in the result register that drives o_*.
// Throughput: one scan per cycle while the output is not stalled; each button's state updates
// as the scan moves from the scan register to the result register.
// Reset (synchronous, active low) clears all button state and the valid flags of both
// pipeline registers, and sets the debounce time to 28 ms and the pressed level to high.
// The block takes a new scan while a finished result is still waiting, if the scan register is empty.
module multi_button_debouncer #(
    parameter int NUM_BUTTONS = 9
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [mbd_pkg::TIME_W-1:0]  i_now_ms,
    input  logic [mbd_pkg::FIELD_W-1:0] i_raw_levels,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [mbd_pkg::FIELD_W-1:0] o_press_mask,
    output logic [mbd_pkg::FIELD_W-1:0] o_stable_mask,
    input  logic                        i_cfg_we,
    input  logic [mbd_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [mbd_pkg::CFG_W-1:0]   i_cfg_wdata
);
    import mbd_pkg::*;

    logic               r_in_valid;
    logic [TIME_W-1:0]  r_now_ms;
    logic [FIELD_W-1:0] r_raw_levels;
    logic               r_out_valid;
    logic [FIELD_W-1:0] r_press_mask;
    logic [FIELD_W-1:0] r_stable_mask;
    logic [DEB_W-1:0]   r_hold_ms;
    logic               r_pressed_level;

    logic                   w_out_free;
    logic                   w_advance;
    logic                   w_in_take;
    t_cfg                   w_cfg;
    logic [NUM_BUTTONS-1:0] w_level;
    logic [NUM_BUTTONS-1:0] w_stable_all;
    logic [NUM_BUTTONS-1:0] w_press_all;
    logic [FIELD_W-1:0]     w_press;
    logic [FIELD_W-1:0]     w_stable;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;

    assign w_cfg.hold_ms       = r_hold_ms;
    assign w_cfg.pressed_level = r_pressed_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ms       <= DEBOUNCE_RESET;
            r_pressed_level <= PRESSED_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_HOLD_MS: begin
                    r_hold_ms <= i_cfg_wdata[DEB_W-1:0];
                end
                REG_PRESSED_LEVEL: begin
                    r_pressed_level <= i_cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_now_ms     <= i_now_ms;
            r_raw_levels <= i_raw_levels;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < NUM_BUTTONS; gi++) begin : g_btn
            // Buttons past the input field always read low.
            if (gi < FIELD_W) begin : g_live
                assign w_level[gi] = r_raw_levels[gi];
            end else begin : g_dead
                assign w_level[gi] = 1'b0;
            end

            mbd_button u_button (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_advance     (w_advance),
                .i_now_ms      (r_now_ms),
                .i_level       (w_level[gi]),
                .i_cfg         (w_cfg),
                .o_stable_next (w_stable_all[gi]),
                .o_press       (w_press_all[gi])
            );
        end

        for (gi = 0; gi < FIELD_W; gi++) begin : g_field
            if (gi < NUM_BUTTONS) begin : g_used
                assign w_press[gi]  = w_press_all[gi];
                assign w_stable[gi] = w_stable_all[gi];
            end else begin : g_unused
                assign w_press[gi]  = 1'b0;
                assign w_stable[gi] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_press_mask  <= w_press;
            r_stable_mask <= w_stable;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_press_mask  = r_press_mask;
    assign o_stable_mask = r_stable_mask;

    // A scan that leaves the scan register always lands in the result register.
    a_advance_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("scan left the scan register without producing a result");

    // A held scan keeps its timestamp until it moves on.
    a_scan_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_now_ms)))
        else $error("held scan was lost or changed");

    // A press transfer only marks buttons whose new stable level is the pressed level.
    a_press_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |-> ((w_press & (w_stable ^ {FIELD_W{r_pressed_level}})) == '0))
        else $error("press flagged on a button not at the pressed level");

endmodule

/* rtl/mbd_button.sv */
// State and debounce decision for one button.
module mbd_button (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_advance,
    input  logic [mbd_pkg::TIME_W-1:0] i_now_ms,
    input  logic                      i_level,
    input  mbd_pkg::t_cfg             i_cfg,
    output logic                      o_stable_next,
    output logic                      o_press
);
    import mbd_pkg::*;

    logic              r_last_raw;
    logic              r_stable;
    logic [TIME_W-1:0] r_change_time;

    logic              n_last_raw;
    logic              n_stable;
    logic [TIME_W-1:0] n_change_time;
    logic [TIME_W-1:0] w_elapsed;
    logic              w_expired;

    assign w_elapsed = i_now_ms - r_change_time;
    assign w_expired = w_elapsed > {{(TIME_W-DEB_W){1'b0}}, i_cfg.hold_ms};

    // A raw change restarts the timer from the scan's time, and the stable level
    // cannot move in the same scan.
    always_comb begin
        n_last_raw    = r_last_raw;
        n_change_time = r_change_time;
        n_stable      = r_stable;
        o_press       = 1'b0;
        if (i_level != r_last_raw) begin
            n_last_raw    = i_level;
            n_change_time = i_now_ms;
        end else if (w_expired && (i_level != r_stable)) begin
            n_stable = i_level;
            o_press  = (i_level == i_cfg.pressed_level);
        end
    end

    assign o_stable_next = n_stable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw    <= 1'b0;
            r_stable      <= 1'b0;
            r_change_time <= '0;
        end else if (i_advance) begin
            r_last_raw    <= n_last_raw;
            r_stable      <= n_stable;
            r_change_time <= n_change_time;
        end
    end

endmodule
